// ===== rtl/pbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbpm_pkg
// Shared types and codes for the packet buffer pool manager.
// ----------------------------------------------------------------------------
package pbpm_pkg;

  localparam int MAX_BUFFERS_DEF = 64;
  localparam int HEAD_ROOM_DEF   = 32;
  localparam int ALIGN           = 16;

  // operation codes
  localparam logic [1:0] OP_GET  = 2'd0;
  localparam logic [1:0] OP_PUT  = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;
  localparam logic [1:0] ST_DOUBLE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_POOL_BASE = 2'd0;
  localparam logic [1:0] REG_BUF_BYTES = 2'd1;
  localparam logic [1:0] REG_BUF_COUNT = 2'd2;

  localparam logic [31:0] CFG_BASE_RESET  = 32'd0;
  localparam logic [15:0] CFG_BYTES_RESET = 16'd2048;
  localparam logic [6:0]  CFG_COUNT_RESET = 7'd64;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request fields
    logic decode;    // evaluate request, update list/counters
    logic walk;      // write one free list entry during init
    logic grant;     // popped index available, start address multiply
    logic addr;      // form buffer address
    logic load_out;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       empty;      // free list empty
    logic       pool_zero;  // configured count is zero
    logic       walk_last;  // last entry of init walk
  } stat_t;

endpackage

// ===== rtl/pbpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbpm_ctrl
// Request sequencer: accepts one request, steps the datapath through it and
// owns the result handshake.
// ----------------------------------------------------------------------------
module pbpm_ctrl import pbpm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_GRANT  = 3'd3;
  localparam logic [2:0] S_ADDR   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.decode   = (state == S_DECODE);
    cmd.walk     = (state == S_WALK);
    cmd.grant    = (state == S_GRANT);
    cmd.addr     = (state == S_ADDR);
    cmd.load_out = (state == S_FIN) && slot_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.op)
          OP_INIT: state_next = stat.pool_zero ? S_FIN : S_WALK;
          OP_GET:  state_next = stat.empty ? S_FIN : S_GRANT;
          default: state_next = S_FIN;
        endcase
      end
      S_WALK: begin
        if (stat.walk_last) state_next = S_FIN;
      end
      S_GRANT: state_next = S_ADDR;
      S_ADDR:  state_next = S_FIN;
      S_FIN: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/pbpm_datapath.sv =====
// ----------------------------------------------------------------------------
// pbpm_datapath
// Configuration registers, free list memory, buffer flags, counters,
// address arithmetic and the result register.
// ----------------------------------------------------------------------------
module pbpm_datapath import pbpm_pkg::*; #(
  parameter int MAX_BUFFERS = MAX_BUFFERS_DEF,
  parameter int HEAD_ROOM   = HEAD_ROOM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  operation,
  input  logic [5:0]  buffer_index,
  output logic [1:0]  status,
  output logic [5:0]  granted_index,
  output logic [31:0] buffer_address,
  output logic [31:0] data_address,
  output logic [31:0] end_address,
  output logic [6:0]  free_total,
  output logic [6:0]  used_total
);

  localparam int IDX_W  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
  localparam int CFG_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
  localparam int SUM_W  = CNT_W + 1;
  localparam int PROD_W = IDX_W + 16;
  localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(MAX_BUFFERS - 1);

  // configuration
  logic [31:0] cfg_base;
  logic [15:0] cfg_bytes;
  logic [6:0]  cfg_count;

  // values latched at init
  logic [CNT_W-1:0] pool_size;
  logic [31:0]      base_l;
  logic [15:0]      size_l;
  logic [31:0]      end_off;

  logic [MAX_BUFFERS-1:0] free_mask;
  logic [IDX_W-1:0]       fifo_mem [MAX_BUFFERS];
  logic [IDX_W-1:0]       fifo_rdata;
  logic [IDX_W-1:0]       rd_ptr;
  logic [IDX_W-1:0]       wr_ptr;
  logic [IDX_W-1:0]       walk_cnt;
  logic [CNT_W-1:0]       free_cnt;
  logic [CNT_W-1:0]       used_cnt;

  logic [1:0]        op_r;
  logic [5:0]        idx_r;
  logic [1:0]        res_status;
  logic              res_get;
  logic [IDX_W-1:0]  gidx_r;
  logic [PROD_W-1:0] prod;
  logic [31:0]       baddr_r;

  logic [CNT_W-1:0] init_n;
  logic             put_bad;
  logic             put_double;
  logic             put_ok;
  logic             pop_en;
  logic             fifo_we;
  logic [IDX_W-1:0] fifo_waddr;
  logic [IDX_W-1:0] fifo_wdata;

  assign cfg_ready = 1'b1;

  assign init_n = (CFG_W'(cfg_count) > CFG_W'(MAX_BUFFERS)) ? CNT_W'(MAX_BUFFERS)
                                                            : CNT_W'(cfg_count);

  assign put_bad    = CMP_W'(idx_r) >= CMP_W'(pool_size);
  assign put_double = free_mask[IDX_W'(idx_r)];
  assign put_ok     = cmd.decode && (op_r == OP_PUT) && !put_bad && !put_double;
  assign pop_en     = cmd.decode && (op_r == OP_GET) && (free_cnt != '0);

  assign fifo_we    = cmd.walk || put_ok;
  assign fifo_waddr = cmd.walk ? walk_cnt : wr_ptr;
  assign fifo_wdata = cmd.walk ? walk_cnt : IDX_W'(idx_r);

  always_comb begin
    stat           = '0;
    stat.op        = op_r;
    stat.empty     = (free_cnt == '0);
    stat.pool_zero = (cfg_count == '0);
    stat.walk_last = (CNT_W'(walk_cnt) == pool_size - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base  <= CFG_BASE_RESET;
      cfg_bytes <= CFG_BYTES_RESET;
      cfg_count <= CFG_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POOL_BASE: cfg_base  <= cfg_data;
        REG_BUF_BYTES: cfg_bytes <= cfg_data[15:0];
        REG_BUF_COUNT: cfg_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // free list storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
  end

  always_ff @(posedge clk) begin
    if (pop_en) fifo_rdata <= fifo_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= '0;
      base_l    <= '0;
      size_l    <= '0;
      end_off   <= '0;
      free_mask <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      walk_cnt  <= '0;
      free_cnt  <= '0;
      used_cnt  <= '0;
    end else begin
      if (cmd.decode && (op_r == OP_INIT)) begin
        pool_size <= init_n;
        base_l    <= (cfg_base + 32'(ALIGN - 1)) & ~32'(ALIGN - 1);
        size_l    <= cfg_bytes;
        end_off   <= {16'd0, cfg_bytes} - 32'd1;
        rd_ptr    <= '0;
        wr_ptr    <= (init_n == CNT_W'(MAX_BUFFERS)) ? '0 : IDX_W'(init_n);
        walk_cnt  <= '0;
        free_cnt  <= init_n;
        used_cnt  <= '0;
        for (int i = 0; i < MAX_BUFFERS; i++) begin
          free_mask[i] <= (CNT_W'(i) < init_n);
        end
      end
      if (cmd.walk) walk_cnt <= walk_cnt + IDX_W'(1);
      if (pop_en) begin
        rd_ptr   <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + IDX_W'(1);
        free_cnt <= free_cnt - CNT_W'(1);
        used_cnt <= used_cnt + CNT_W'(1);
      end
      if (put_ok) begin
        free_mask[IDX_W'(idx_r)] <= 1'b1;
        wr_ptr   <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + IDX_W'(1);
        free_cnt <= free_cnt + CNT_W'(1);
        if (used_cnt != '0) used_cnt <= used_cnt - CNT_W'(1);
      end
      if (cmd.grant) free_mask[fifo_rdata] <= 1'b0;
    end
  end

  // request and result working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= operation;
      idx_r <= buffer_index;
    end
    if (cmd.decode) begin
      res_get    <= 1'b0;
      res_status <= ST_OK;
      if ((op_r == OP_GET) && (free_cnt == '0)) begin
        res_status <= ST_EMPTY;
      end else if (op_r == OP_PUT) begin
        if (put_bad)         res_status <= ST_BADIDX;
        else if (put_double) res_status <= ST_DOUBLE;
      end
    end
    if (cmd.grant) begin
      gidx_r  <= fifo_rdata;
      prod    <= PROD_W'(fifo_rdata) * PROD_W'(size_l);
      res_get <= 1'b1;
    end
    if (cmd.addr) baddr_r <= base_l + 32'(prod);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status         <= res_status;
      granted_index  <= res_get ? 6'(gidx_r) : 6'd0;
      buffer_address <= res_get ? baddr_r : 32'd0;
      data_address   <= res_get ? baddr_r + 32'(HEAD_ROOM) : 32'd0;
      end_address    <= res_get ? baddr_r + end_off : 32'd0;
      free_total     <= 7'(free_cnt);
      used_total     <= 7'(used_cnt);
    end
  end

  // free plus used never exceeds the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(free_cnt) + SUM_W'(used_cnt) <= SUM_W'(pool_size))
    else $error("free and used counts exceed pool size");

  // a pop takes exactly one buffer off the free count
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop_en |=> free_cnt == $past(free_cnt) - CNT_W'(1))
    else $error("pop did not decrement free count");

  // a granted buffer is no longer marked free
  a_grant_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.grant |=> !free_mask[$past(fifo_rdata)])
    else $error("granted buffer still flagged free");

  // a put never lands in the list while it is full
  a_put_room: assert property (@(posedge clk) disable iff (rst)
    put_ok |-> free_cnt < pool_size)
    else $error("put pushed onto a full free list");

endmodule

// ===== rtl/packet_buffer_pool_manager_top.sv =====
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager_top
// Pool of equal-size packet buffers on a FIFO free list: init, get, put.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | operation, buffer_index
//  out      | out_valid / out_stall| status, granted_index, buffer_address,
//           |                      | data_address, end_address, free_total,
//           |                      | used_total
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready always 1)
//
// One request at a time. From accept to result register a get passes through
// free list read, index * size multiply and address add; put and other
// requests go straight to the result, and init first writes one free list
// entry per cycle. The input reopens the cycle after the result is loaded.
// A result waiting on out_stall holds; the next request is
// still accepted and its result waits in the final step for the slot.
// Reset is synchronous; the free list memory has no reset.
// ----------------------------------------------------------------------------
module packet_buffer_pool_manager_top import pbpm_pkg::*; #(
  parameter int MAX_BUFFERS = MAX_BUFFERS_DEF,
  parameter int HEAD_ROOM   = HEAD_ROOM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [5:0]  buffer_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  granted_index,
  output logic [31:0] buffer_address,
  output logic [31:0] data_address,
  output logic [31:0] end_address,
  output logic [6:0]  free_total,
  output logic [6:0]  used_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  pbpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbpm_datapath #(
    .MAX_BUFFERS (MAX_BUFFERS),
    .HEAD_ROOM   (HEAD_ROOM)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .buffer_index   (buffer_index),
    .status         (status),
    .granted_index  (granted_index),
    .buffer_address (buffer_address),
    .data_address   (data_address),
    .end_address    (end_address),
    .free_total     (free_total),
    .used_total     (used_total)
  );

endmodule

// ===== test/packet_buffer_pool_manager_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager_top_test
// Drives init, get, put and no-op requests into the pool manager under
// random input gaps and output stalls, predicts every result from a
// cycle-free model of the free list, and compares each result field by field.
// ----------------------------------------------------------------------------
module packet_buffer_pool_manager_top_test;
  import pbpm_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;  // unused code, block answers ok
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 4000;

  typedef enum logic [1:0] {BUF_RELEASED, BUF_FREE, BUF_ALLOC} buf_state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] index;
  } pool_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  granted_index;
    logic [31:0] buffer_address;
    logic [31:0] data_address;
    logic [31:0] end_address;
    logic [6:0]  free_total;
    logic [6:0]  used_total;
  } pool_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_NOP;
  logic [5:0]  buffer_index = 6'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [5:0]  granted_index;
  logic [31:0] buffer_address;
  logic [31:0] data_address;
  logic [31:0] end_address;
  logic [6:0]  free_total;
  logic [6:0]  used_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_POOL_BASE;
  logic [31:0] cfg_data = 32'd0;

  packet_buffer_pool_manager_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .buffer_index(buffer_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .granted_index(granted_index),
    .buffer_address(buffer_address), .data_address(data_address),
    .end_address(end_address), .free_total(free_total), .used_total(used_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register copies, as written
  logic [31:0] cfg_base = CFG_BASE_RESET;
  logic [15:0] cfg_bytes = CFG_BYTES_RESET;
  logic [6:0]  cfg_count = CFG_COUNT_RESET;

  // pool state as the block should hold it
  buf_state_t  buffer_state [MAX_BUFFERS_DEF];
  logic [5:0]  free_list [MAX_BUFFERS_DEF];
  logic [5:0]  list_head = '0;
  logic [5:0]  list_tail = '0;
  int          free_count = 0;
  int          used_count = 0;
  int          pool_size = 0;
  logic [31:0] latched_base = '0;
  logic [15:0] latched_bytes = '0;

  pool_request_t pending_requests [$];
  pool_result_t  expected_results [$];
  pool_request_t next_request;

  int error_count = 0;
  int stuck_cycles = 0;
  bit quiet = 1'b0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;

  initial begin
    foreach (buffer_state[i]) begin
      buffer_state[i] = BUF_RELEASED;
      free_list[i] = '0;
    end
  end

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic pool_result_t predict_pool_result(logic [1:0] op, logic [5:0] idx);
    pool_result_t r;
    logic [5:0] b;
    int i;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INIT: begin
        pool_size = (cfg_count > MAX_BUFFERS_DEF) ? MAX_BUFFERS_DEF : cfg_count;
        latched_base = (cfg_base + 32'd15) & 32'hFFFF_FFF0;
        latched_bytes = cfg_bytes;
        list_head = '0;
        list_tail = '0;
        free_count = 0;
        used_count = 0;
        for (i = 0; i < MAX_BUFFERS_DEF; i++) begin
          if (i < pool_size) begin
            buffer_state[i] = BUF_FREE;
            free_list[list_tail] = 6'(i);
            list_tail++;
            free_count++;
          end else begin
            buffer_state[i] = BUF_RELEASED;
          end
        end
      end
      OP_GET: begin
        if (free_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          b = free_list[list_head];
          list_head++;
          free_count--;
          buffer_state[b] = BUF_ALLOC;
          used_count++;
          r.granted_index = b;
          r.buffer_address = latched_base + {26'd0, b} * {16'd0, latched_bytes};
          r.data_address = r.buffer_address + 32'(HEAD_ROOM_DEF);
          r.end_address = r.buffer_address + {16'd0, latched_bytes} - 32'd1;
        end
      end
      OP_PUT: begin
        if (idx >= pool_size) begin
          r.status = ST_BADIDX;
        end else if (buffer_state[idx] == BUF_FREE) begin
          r.status = ST_DOUBLE;
        end else begin
          buffer_state[idx] = BUF_FREE;
          free_list[list_tail] = idx;
          list_tail++;
          free_count++;
          if (used_count > 0) used_count--;
        end
      end
      default: ;
    endcase
    r.free_total = 7'(free_count);
    r.used_total = 7'(used_count);
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic check_result();
    pool_result_t want;
    if (expected_results.size() == 0) begin
      report_error($sformatf("result with no request outstanding, status %0d", status));
      return;
    end
    want = expected_results.pop_front();
    check_field("status", 32'(status), 32'(want.status));
    check_field("granted_index", 32'(granted_index), 32'(want.granted_index));
    check_field("buffer_address", buffer_address, want.buffer_address);
    check_field("data_address", data_address, want.data_address);
    check_field("end_address", end_address, want.end_address);
    check_field("free_total", 32'(free_total), 32'(want.free_total));
    check_field("used_total", 32'(used_total), 32'(want.used_total));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_pool_result(operation, buffer_index));
      end
      if (!in_valid || !in_stall) begin
        if (send_calm > 0) send_calm--;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_request = pending_requests.pop_front();
          in_valid <= 1'b1;
          operation <= next_request.op;
          buffer_index <= next_request.index;
          if (!quiet && send_calm == 0) begin
            if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(50, 150);
            else if ($urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_arm && !hold_done) begin
        // long hold so the block backs up into its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        if (recv_calm > 0) recv_calm--;
        else if (!quiet && $urandom_range(0, 99) == 0) recv_calm = $urandom_range(50, 150);
        if (!quiet && recv_calm == 0 && $urandom_range(0, 9) == 0) begin
          recv_gap = $urandom_range(0, 13);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_register(logic [1:0] index, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_POOL_BASE: cfg_base = value;
      REG_BUF_BYTES: cfg_bytes = value[15:0];
      REG_BUF_COUNT: cfg_count = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_pool(logic [31:0] base, logic [15:0] bytes, logic [6:0] count);
    write_register(REG_POOL_BASE, base);
    write_register(REG_BUF_BYTES, {16'd0, bytes});
    write_register(REG_BUF_COUNT, {25'd0, count});
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic push_request(logic [1:0] op, logic [5:0] idx);
    pending_requests.push_back('{op: op, index: idx});
  endtask

  task automatic queue_requests(int count, int pool_n, int get_pct);
    pool_request_t r;
    int k;
    int roll;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      r.index = 6'($urandom);
      if (roll < 2) r.op = OP_INIT;
      else if (roll < 5) r.op = OP_NOP;
      else if (roll < 5 + get_pct) r.op = OP_GET;
      else begin
        r.op = OP_PUT;
        // most puts name a buffer inside the pool so they can succeed
        if (roll < 95) r.index = 6'($urandom_range(0, pool_n - 1));
      end
      pending_requests.push_back(r);
    end
  endtask

  initial begin
    int phase;
    int pool_n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // before any init: nothing to put, nothing to get
    push_request(OP_PUT, 6'd5);
    push_request(OP_GET, 6'd0);
    push_request(OP_NOP, 6'd63);
    // reset registers: 64 buffers of 2048 bytes at address zero
    push_request(OP_INIT, 6'd0);
    push_request(OP_GET, 6'd63);
    push_request(OP_GET, 6'd0);
    push_request(OP_PUT, 6'd63);
    push_request(OP_PUT, 6'd1);
    push_request(OP_PUT, 6'd1);
    push_request(OP_PUT, 6'd0);
    push_request(OP_NOP, 6'd0);
    wait_idle();

    // base rounds up past the top of the address space; count clamps to 64
    set_pool(32'hFFFF_FFF1, 16'hFFFF, 7'd127);
    push_request(OP_INIT, 6'd0);
    push_request(OP_GET, 6'd0);
    push_request(OP_PUT, 6'd63);
    push_request(OP_GET, 6'd0);
    wait_idle();

    // empty pool
    set_pool(32'h0000_0010, 16'd2048, 7'd0);
    push_request(OP_INIT, 6'd0);
    push_request(OP_GET, 6'd0);
    push_request(OP_PUT, 6'd0);
    wait_idle();

    // single smallest buffer
    set_pool(32'h0, 16'd16, 7'd1);
    push_request(OP_INIT, 6'd0);
    push_request(OP_GET, 6'd0);
    push_request(OP_GET, 6'd0);
    push_request(OP_PUT, 6'd0);
    push_request(OP_PUT, 6'd0);
    push_request(OP_PUT, 6'd63);
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: pool_n = 64;
        1: pool_n = 64;
        2: pool_n = $urandom_range(1, 8);
        3: pool_n = 64;
        default: pool_n = $urandom_range(1, 64);
      endcase
      case (phase)
        1: set_pool(32'hFFFF_FFFF, 16'hFFFF, 7'(pool_n));
        2: set_pool(32'h0, 16'd16, 7'(pool_n));
        default: set_pool($urandom, 16'($urandom_range(16, 65535)), 7'(pool_n));
      endcase
      if (phase == 3) hold_arm = 1'b1;
      if (phase == 5) quiet = 1'b1;
      push_request(OP_INIT, 6'($urandom));
      case (phase)
        0: queue_requests(240, pool_n, 60);
        1: queue_requests(240, pool_n, 70);
        2: queue_requests(240, pool_n, 45);
        3: queue_requests(240, pool_n, 50);
        default: queue_requests(240, pool_n, 40);
      endcase
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== packet_buffer_pool_manager_top.f =====
rtl/pbpm_pkg.sv
rtl/pbpm_ctrl.sv
rtl/pbpm_datapath.sv
rtl/packet_buffer_pool_manager_top.sv
test/packet_buffer_pool_manager_top_test.sv
